FILE: hdl/ihx_pkg.sv
package ihx_pkg;

    parameter int unsigned RECORD_BYTES = 16;
    localparam logic [4:0] RecordBytesW = 5'(RECORD_BYTES);

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    // record kinds are coded by their record type byte
    localparam logic [2:0] KIND_DATA  = 3'd0;
    localparam logic [2:0] KIND_EOF   = 3'd1;
    localparam logic [2:0] KIND_EXT   = 3'd4;
    localparam logic [2:0] KIND_START = 3'd5;

    localparam logic [2:0] FLD_LEN     = 3'd0;
    localparam logic [2:0] FLD_ADDR_HI = 3'd1;
    localparam logic [2:0] FLD_ADDR_LO = 3'd2;
    localparam logic [2:0] FLD_TYPE    = 3'd3;
    localparam logic [2:0] FLD_DATA    = 3'd4;
    localparam logic [2:0] FLD_CSUM    = 3'd5;

    localparam logic [1:0] CH_COLON   = 2'd0;
    localparam logic [1:0] CH_HI      = 2'd1;
    localparam logic [1:0] CH_LO      = 2'd2;
    localparam logic [1:0] CH_NEWLINE = 2'd3;

    localparam logic [7:0] AsciiColon   = 8'h3A;
    localparam logic [7:0] AsciiNewline = 8'h0A;
    localparam logic [7:0] AsciiZero    = 8'h30;
    localparam logic [7:0] AsciiNine    = 8'h39;
    localparam logic [7:0] AsciiUpperA  = 8'h41;
    localparam logic [7:0] AsciiUpperF  = 8'h46;

    typedef struct packed {
        logic       accept;
        logic       emit;
        logic [1:0] char_sel;
        logic [2:0] field;
        logic [2:0] kind;
        logic [3:0] idx;
        logic [3:0] rd_idx;
        logic       last;
        logic       ext_clear;
        logic       flush_done;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       ext_pending;
        logic [4:0] fill;
        logic       flush_cond;
        logic [4:0] rec_len;
        logic       out_free;
    } t_dp_status;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        return (nib < 4'd10) ? (AsciiZero + wide) : (AsciiUpperA - 8'd10 + wide);
    endfunction

endpackage

FILE: hdl/ihx_in_if.sv
interface ihx_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] value;
    logic [7:0]  data_byte;

    modport source (output valid, output command, output value, output data_byte,
                    input ready);
    modport sink   (input valid, input command, input value, input data_byte,
                    output ready);
endinterface

FILE: hdl/ihx_out_if.sv
interface ihx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last;

    modport source (output valid, output text_char, output last, input ready);
    modport sink   (input valid, input text_char, input last, output ready);
endinterface

FILE: hdl/ihx_datapath.sv
module ihx_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ihx_pkg::t_dp_cmd    i_cmd,
    input  logic [1:0]          i_command,
    input  logic [31:0]         i_value,
    input  logic [7:0]          i_data_byte,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [7:0]          o_text_char,
    output logic                o_last,
    output ihx_pkg::t_dp_status o_status
);
    import ihx_pkg::*;

    logic [7:0]  r_buf [16];
    logic [7:0]  r_rd;
    logic [4:0]  r_fill;
    logic [15:0] r_low;
    logic [15:0] r_upper;
    logic        r_ext;
    logic [1:0]  r_cmd;
    logic [31:0] r_value;
    logic [7:0]  r_sum;
    logic        r_out_valid;
    logic [7:0]  r_char;
    logic        r_last;

    logic [4:0]  rec_len;
    logic [7:0]  cur_byte;
    logic [7:0]  n_char;
    logic [16:0] adv_sum;
    logic        out_free;

    assign adv_sum  = {1'b0, r_low} + {12'd0, r_fill};
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.kind)
            KIND_EXT:   rec_len = 5'd2;
            KIND_DATA:  rec_len = r_fill;
            KIND_START: rec_len = 5'd4;
            default:    rec_len = 5'd0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.field)
            FLD_LEN:     cur_byte = {3'd0, rec_len};
            FLD_ADDR_HI: cur_byte = (i_cmd.kind == KIND_DATA) ? r_low[15:8] : 8'd0;
            FLD_ADDR_LO: cur_byte = (i_cmd.kind == KIND_DATA) ? r_low[7:0] : 8'd0;
            FLD_TYPE:    cur_byte = {5'd0, i_cmd.kind};
            FLD_DATA: begin
                case (i_cmd.kind)
                    KIND_EXT:   cur_byte = i_cmd.idx[0] ? r_upper[7:0] : r_upper[15:8];
                    KIND_DATA:  cur_byte = r_rd;
                    KIND_START: begin
                        case (i_cmd.idx[1:0])
                            2'd0:    cur_byte = r_value[31:24];
                            2'd1:    cur_byte = r_value[23:16];
                            2'd2:    cur_byte = r_value[15:8];
                            default: cur_byte = r_value[7:0];
                        endcase
                    end
                    default:    cur_byte = 8'd0;
                endcase
            end
            FLD_CSUM:    cur_byte = 8'd0 - r_sum;
            default:     cur_byte = 8'd0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.char_sel)
            CH_COLON: n_char = AsciiColon;
            CH_HI:    n_char = hex_char(cur_byte[7:4]);
            CH_LO:    n_char = hex_char(cur_byte[3:0]);
            default:  n_char = AsciiNewline;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_command == CMD_DATA) begin
            r_buf[r_fill[3:0]] <= i_data_byte;
        end
        r_rd <= r_buf[i_cmd.rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd   <= i_command;
            r_value <= i_value;
        end
        if (i_cmd.emit) begin
            r_char <= n_char;
            r_last <= i_cmd.last;
            if (i_cmd.char_sel == CH_COLON) begin
                r_sum <= 8'd0;
            end else if (i_cmd.char_sel == CH_LO && i_cmd.field != FLD_CSUM) begin
                r_sum <= r_sum + cur_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 5'd0;
            r_low       <= 16'd0;
            r_upper     <= 16'd0;
            r_ext       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && i_command == CMD_BEGIN) begin
                r_upper <= i_value[31:16];
                r_low   <= i_value[15:0];
                r_ext   <= 1'b1;
                r_fill  <= 5'd0;
            end else if (i_cmd.accept && i_command == CMD_DATA) begin
                r_fill <= r_fill + 5'd1;
            end else if (i_cmd.ext_clear) begin
                r_ext <= 1'b0;
            end else if (i_cmd.flush_done) begin
                r_low  <= adv_sum[15:0];
                r_fill <= 5'd0;
                if (adv_sum[16]) begin
                    r_upper <= r_upper + 16'd1;
                    r_ext   <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_char;
    assign o_last      = r_last;

    assign o_status.cmd         = r_cmd;
    assign o_status.ext_pending = r_ext;
    assign o_status.fill        = r_fill;
    assign o_status.flush_cond  = (r_fill >= RecordBytesW) || r_fill[4] ||
                                  (adv_sum == 17'h10000);
    assign o_status.rec_len     = rec_len;
    assign o_status.out_free    = out_free;

endmodule

FILE: hdl/ihx_ctrl.sv
module ihx_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ihx_pkg::t_dp_status i_status,
    output ihx_pkg::t_dp_cmd    o_cmd
);
    import ihx_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_COLON    = 3'd2;
    localparam logic [2:0] S_HI       = 3'd3;
    localparam logic [2:0] S_LO       = 3'd4;
    localparam logic [2:0] S_NL       = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_kind,  n_kind;
    logic [2:0] r_field, n_field;
    logic [3:0] r_idx,   n_idx;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_field = r_field;
        n_idx   = r_idx;
        o_in_ready       = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.emit       = 1'b0;
        o_cmd.char_sel   = CH_COLON;
        o_cmd.last       = 1'b0;
        o_cmd.ext_clear  = 1'b0;
        o_cmd.flush_done = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_field = FLD_LEN;
                n_idx   = 4'd0;
                n_state = S_COLON;
                unique case (i_status.cmd)
                    CMD_DATA: begin
                        if (i_status.ext_pending) begin
                            n_kind          = KIND_EXT;
                            o_cmd.ext_clear = 1'b1;
                        end else if (i_status.flush_cond) begin
                            n_kind = KIND_DATA;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    CMD_END: begin
                        n_kind = KIND_DATA;
                        if (i_status.fill == 5'd0) begin
                            n_state = S_IDLE;
                        end
                    end
                    CMD_FINISH: n_kind = KIND_START;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_COLON: begin
                o_cmd.char_sel = CH_COLON;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_HI;
                end
            end
            S_HI: begin
                o_cmd.char_sel = CH_HI;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_LO;
                end
            end
            S_LO: begin
                o_cmd.char_sel = CH_LO;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_HI;
                    unique case (r_field)
                        FLD_LEN:     n_field = FLD_ADDR_HI;
                        FLD_ADDR_HI: n_field = FLD_ADDR_LO;
                        FLD_ADDR_LO: n_field = FLD_TYPE;
                        FLD_TYPE: begin
                            n_field = (i_status.rec_len == 5'd0) ? FLD_CSUM : FLD_DATA;
                        end
                        FLD_DATA: begin
                            if (({1'b0, r_idx} + 5'd1) == i_status.rec_len) begin
                                n_field = FLD_CSUM;
                                n_idx   = 4'd0;
                            end else begin
                                n_idx = r_idx + 4'd1;
                            end
                        end
                        default: n_state = S_NL;
                    endcase
                end
            end
            S_NL: begin
                o_cmd.char_sel = CH_NEWLINE;
                if (r_kind == KIND_EXT) begin
                    o_cmd.last = !i_status.flush_cond;
                end else begin
                    o_cmd.last = (r_kind != KIND_START);
                end
                if (i_status.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.flush_done = (r_kind == KIND_DATA);
                    n_field          = FLD_LEN;
                    n_idx            = 4'd0;
                    n_state          = S_IDLE;
                    if (r_kind == KIND_EXT && i_status.flush_cond) begin
                        n_kind  = KIND_DATA;
                        n_state = S_COLON;
                    end else if (r_kind == KIND_START) begin
                        n_kind  = KIND_EOF;
                        n_state = S_COLON;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        o_cmd.field  = r_field;
        o_cmd.kind   = r_kind;
        o_cmd.idx    = r_idx;
        o_cmd.rd_idx = n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_DATA;
            r_field <= FLD_LEN;
            r_idx   <= 4'd0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_field <= n_field;
            r_idx   <= n_idx;
        end
    end

endmodule

FILE: hdl/intel_hex_record_encoder.sv
// Intel HEX (I32HEX) record encoder. Each input beat carries a command: begin latches a 32-bit
// load address, data buffers one byte, end flushes a partial record, finish emits the start
// linear address and EOF records. Output beats carry one ASCII character each (colon, uppercase
// hex digit or newline), with last set on the final character caused by an input beat. An input
// beat is taken in one cycle and decoded in the next; a data byte that causes no record frees
// the input again straight from the decode state. A record of n data bytes is 2*n + 12
// characters, which leave through the single output register and are held back by any output
// stall: 44 characters for a full 16-byte data record, 16 for an extended address record. A
// finish frees the input again once its two records are sent. Buffered bytes sit in a 16-entry
// memory read one byte per two characters.
module intel_hex_record_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ihx_in_if.sink     i_in,
    ihx_out_if.source  o_out
);
    import ihx_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status st;

    ihx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (st),
        .o_cmd      (cmd)
    );

    ihx_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_command   (i_in.command),
        .i_value     (i_in.value),
        .i_data_byte (i_in.data_byte),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_text_char (o_out.text_char),
        .o_last      (o_out.last),
        .o_status    (st)
    );

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while previous item still in work");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.text_char == AsciiColon || o_out.text_char == AsciiNewline ||
                         (o_out.text_char >= AsciiZero && o_out.text_char <= AsciiNine) ||
                         (o_out.text_char >= AsciiUpperA && o_out.text_char <= AsciiUpperF)))
        else $error("character outside record alphabet");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.fill <= RecordBytesW)
        else $error("byte buffer overfilled");

endmodule
